// ===== hw/rtl/pmml_pkg.sv =====
`timescale 1ns / 1ps

package pmml_pkg;

    localparam int MAX_NODES     = 64;
    localparam int NODE_AW       = $clog2(MAX_NODES);
    localparam int NODE_CW       = $clog2(MAX_NODES + 1);
    localparam int MAX_ENTRIES   = 1024;
    localparam int ENTRY_AW      = $clog2(MAX_ENTRIES);
    localparam int ENTRY_CW      = $clog2(MAX_ENTRIES + 1);
    localparam int MAX_PARTICLES = 256;
    localparam int PART_W        = $clog2(MAX_PARTICLES);

    localparam int W_W      = 16;
    localparam int NODE_W   = 16;
    localparam int MASS_W   = 16;
    localparam int SUM_W    = 22;   // up to MAX_NODES weights of one particle
    localparam int PROD1_W  = MASS_W + W_W;
    localparam int PROD2_W  = PROD1_W + SUM_W;
    localparam int ACC_W    = 62;   // worst case lump sum stays below 2^62
    localparam int VALUE_W  = 63;
    localparam logic [15:0] MASS_RESET = 16'd256;

    typedef enum logic [2:0] {
        ACT_ADD   = 3'd0,
        ACT_LOAD  = 3'd1,
        ACT_LUMP  = 3'd2,
        ACT_QUERY = 3'd3,
        ACT_CLEAR = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DROP  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_SAT   = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_CMP,
        S_ADD_DECIDE,
        S_ADD_SH_RD,
        S_ADD_SH_WR,
        S_ADD_PUT,
        S_LOAD_RD,
        S_LOAD_CMP,
        S_LOAD_DECIDE,
        S_NODE_RD,
        S_NODE_GOT,
        S_SCAN_START,
        S_ENT_RD,
        S_ENT_GOT,
        S_TAB_GOT,
        S_MUL2,
        S_ACC,
        S_SCAN_DONE,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic clr;
        logic ld;
        logic mul;
        logic acc;
    } mac_ctrl_t;

    typedef struct packed {
        logic [PART_W-1:0] part;
        logic [NODE_W-1:0] node;
        logic [W_W-1:0]    weight;
    } ent_t;

endpackage

// ===== hw/rtl/pmml_mac.sv =====
`timescale 1ns / 1ps

module pmml_mac
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pmml_pkg::mac_ctrl_t           ctrl,
    input  logic [pmml_pkg::MASS_W-1:0]   mass,
    input  logic [pmml_pkg::W_W-1:0]      weight,
    input  logic [pmml_pkg::SUM_W-1:0]    factor,
    output logic [pmml_pkg::ACC_W-1:0]    acc
);

    logic [pmml_pkg::PROD1_W-1:0] p1_reg;
    logic [pmml_pkg::SUM_W-1:0]   t_reg;
    logic [pmml_pkg::PROD2_W-1:0] p2_reg;
    logic [pmml_pkg::ACC_W-1:0]   acc_reg;
    logic [pmml_pkg::ACC_W-1:0]   acc_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.ld)
        begin
            p1_reg <= mass * weight;
            t_reg  <= factor;
        end
        if (ctrl.mul)
        begin
            p2_reg <= p1_reg * t_reg;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clr)
        begin
            acc_next = '0;
        end
        else if (ctrl.acc)
        begin
            acc_next = acc_reg + pmml_pkg::ACC_W'(p2_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== hw/rtl/particle_mass_matrix_lumper.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake        Payload
// s_*       in   tvalid/tready    tdata: particle, node_a, node_b, weight; tuser: action
// m_*       out  tvalid/tready    tdata: value, node; tuser: status; tlast: last
// APB       in   psel/penable     register 0 particle_mass at byte 0
//
// Add node: a search of the node set, then one shift per entry that has to move up.
// Load weight: a duplicate search in the entry memory.
// Query: two walks of the entry memory; a matching entry adds a table step on the first
// walk, and a table step, a multiply and an accumulate step on the second.
// Lump: node_count+node_count walks of the entry memory; the single entry read port sets this.
// Reset empties the node set and weight table at once; particle_mass returns to 1.0.
// A result leaves for the output register; while that register is still stalled, the next
// result holds in place and no input is taken meanwhile.

module particle_mass_matrix_lumper
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // particle[7:0], node_a[23:8], node_b[39:24], weight[55:40]
    input  logic [2:0]  s_tuser,   // action[2:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // value[62:0], node[78:63], zero pad[79]
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NCW = pmml_pkg::NODE_CW;
    localparam int ECW = pmml_pkg::ENTRY_CW;

    // memories
    logic [pmml_pkg::NODE_W-1:0] node_mem [pmml_pkg::MAX_NODES];
    pmml_pkg::ent_t              ent_mem  [pmml_pkg::MAX_ENTRIES];
    logic [pmml_pkg::SUM_W-1:0]  tab_mem  [pmml_pkg::MAX_PARTICLES];

    logic [pmml_pkg::NODE_AW-1:0] node_raddr, node_waddr;
    logic                         node_we;
    logic [pmml_pkg::NODE_W-1:0]  node_wdata, node_rdata_reg;
    logic [pmml_pkg::ENTRY_AW-1:0] ent_raddr, ent_waddr;
    logic                          ent_we;
    pmml_pkg::ent_t                ent_wdata, ent_rdata_reg;
    logic [pmml_pkg::PART_W-1:0]   tab_raddr, tab_waddr;
    logic                          tab_we;
    logic [pmml_pkg::SUM_W-1:0]    tab_wdata, tab_rdata_reg;

    // control state
    pmml_pkg::state_t  state_reg, state_next;
    pmml_pkg::action_t act_reg, act_next;
    logic [pmml_pkg::MASS_W-1:0] mass_reg, mass_next;
    logic [NCW-1:0] node_count_reg, node_count_next;
    logic [ECW-1:0] entry_count_reg, entry_count_next;
    logic [NCW-1:0] idx_reg, idx_next;
    logic [NCW-1:0] pos_reg, pos_next;
    logic [ECW-1:0] eidx_reg, eidx_next;
    logic           sum_phase_reg, sum_phase_next;
    logic [pmml_pkg::MAX_PARTICLES-1:0] valid_reg, valid_next;
    logic           m_tvalid_reg, m_tvalid_next;

    // payload
    logic [pmml_pkg::PART_W-1:0] part_reg, part_next;
    logic [pmml_pkg::NODE_W-1:0] na_reg, na_next;
    logic [pmml_pkg::NODE_W-1:0] nb_reg, nb_next;
    logic [pmml_pkg::W_W-1:0]    w_reg, w_next;
    logic [pmml_pkg::NODE_W-1:0] key_reg, key_next;
    logic [pmml_pkg::PART_W-1:0] hold_part_reg, hold_part_next;
    logic [pmml_pkg::W_W-1:0]    hold_w_reg, hold_w_next;
    logic [pmml_pkg::NODE_W-1:0] res_node_reg, res_node_next;
    pmml_pkg::status_t           res_status_reg, res_status_next;
    logic                        res_last_reg, res_last_next;
    logic [pmml_pkg::ACC_W-1:0]  out_value_reg, out_value_next;
    logic [pmml_pkg::NODE_W-1:0] out_node_reg, out_node_next;
    pmml_pkg::status_t           out_status_reg, out_status_next;
    logic                        out_last_reg, out_last_next;

    pmml_pkg::mac_ctrl_t          mac_ctrl;
    logic [pmml_pkg::ACC_W-1:0]   mac_acc;

    logic in_xfer, cfg_wr, scan_end, node_end;
    logic [pmml_pkg::SUM_W-1:0] tab_old;

    assign in_xfer  = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_tready = (state_reg == pmml_pkg::S_IDLE);
    assign scan_end = (ECW'(eidx_reg + 1'b1) == entry_count_reg);
    assign node_end = (NCW'(idx_reg + 1'b1) == node_count_reg);
    assign tab_old  = valid_reg[hold_part_reg] ? tab_rdata_reg : '0;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {16'd0, mass_reg};

    pmml_mac u_mac
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .mass   (mass_reg),
        .weight (hold_w_reg),
        .factor (tab_rdata_reg),
        .acc    (mac_acc)
    );

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_rdata_reg <= node_mem[node_raddr];
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        ent_rdata_reg <= ent_mem[ent_raddr];
        if (tab_we)
        begin
            tab_mem[tab_waddr] <= tab_wdata;
        end
        tab_rdata_reg <= tab_mem[tab_raddr];
    end

    always_comb
    begin
        state_next       = state_reg;
        act_next         = act_reg;
        mass_next        = cfg_wr && !paddr[2] ? pwdata[15:0] : mass_reg;
        node_count_next  = node_count_reg;
        entry_count_next = entry_count_reg;
        idx_next         = idx_reg;
        pos_next         = pos_reg;
        eidx_next        = eidx_reg;
        sum_phase_next   = sum_phase_reg;
        valid_next       = valid_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        part_next        = part_reg;
        na_next          = na_reg;
        nb_next          = nb_reg;
        w_next           = w_reg;
        key_next         = key_reg;
        hold_part_next   = hold_part_reg;
        hold_w_next      = hold_w_reg;
        res_node_next    = res_node_reg;
        res_status_next  = res_status_reg;
        res_last_next    = res_last_reg;
        out_value_next   = out_value_reg;
        out_node_next    = out_node_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;
        mac_ctrl         = '0;
        node_raddr       = idx_reg[pmml_pkg::NODE_AW-1:0];
        node_we          = 1'b0;
        node_waddr       = idx_reg[pmml_pkg::NODE_AW-1:0];
        node_wdata       = node_rdata_reg;
        ent_raddr        = eidx_reg[pmml_pkg::ENTRY_AW-1:0];
        ent_we           = 1'b0;
        ent_waddr        = entry_count_reg[pmml_pkg::ENTRY_AW-1:0];
        ent_wdata        = '{part: part_reg, node: na_reg, weight: w_reg};
        tab_raddr        = ent_rdata_reg.part;
        tab_we           = 1'b0;
        tab_waddr        = hold_part_reg;
        tab_wdata        = tab_old + pmml_pkg::SUM_W'(hold_w_reg);

        unique case (state_reg)
            pmml_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    act_next        = pmml_pkg::action_t'(s_tuser);
                    part_next       = s_tdata[7:0];
                    na_next         = s_tdata[23:8];
                    nb_next         = s_tdata[39:24];
                    w_next          = s_tdata[55:40];
                    mac_ctrl.clr    = 1'b1;
                    idx_next        = '0;
                    pos_next        = '0;
                    eidx_next       = '0;
                    sum_phase_next  = 1'b0;
                    res_node_next   = s_tdata[23:8];
                    res_status_next = pmml_pkg::ST_OK;
                    res_last_next   = 1'b1;
                    case (pmml_pkg::action_t'(s_tuser))
                        pmml_pkg::ACT_ADD:
                        begin
                            state_next = (node_count_reg == '0) ? pmml_pkg::S_ADD_DECIDE
                                                                : pmml_pkg::S_ADD_RD;
                        end
                        pmml_pkg::ACT_LOAD:
                        begin
                            state_next = (entry_count_reg == '0) ? pmml_pkg::S_LOAD_DECIDE
                                                                 : pmml_pkg::S_LOAD_RD;
                        end
                        pmml_pkg::ACT_LUMP:
                        begin
                            valid_next = '0;
                            if (node_count_reg == '0)
                            begin
                                res_node_next   = '0;
                                res_status_next = pmml_pkg::ST_EMPTY;
                                state_next      = pmml_pkg::S_EMIT;
                            end
                            else
                            begin
                                state_next = pmml_pkg::S_NODE_RD;
                            end
                        end
                        pmml_pkg::ACT_QUERY:
                        begin
                            valid_next = '0;
                            key_next   = s_tdata[23:8];
                            state_next = pmml_pkg::S_SCAN_START;
                        end
                        pmml_pkg::ACT_CLEAR:
                        begin
                            node_count_next  = '0;
                            entry_count_next = '0;
                            res_node_next    = '0;
                            state_next       = pmml_pkg::S_EMIT;
                        end
                        default:
                        begin
                            state_next = pmml_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            pmml_pkg::S_ADD_RD:
            begin
                state_next = pmml_pkg::S_ADD_CMP;
            end

            pmml_pkg::S_ADD_CMP:
            begin
                if (node_rdata_reg == na_reg)
                begin
                    state_next = pmml_pkg::S_EMIT;
                end
                else
                begin
                    if (node_rdata_reg < na_reg)
                    begin
                        pos_next = NCW'(idx_reg + 1'b1);
                    end
                    idx_next   = NCW'(idx_reg + 1'b1);
                    state_next = node_end ? pmml_pkg::S_ADD_DECIDE : pmml_pkg::S_ADD_RD;
                end
            end

            pmml_pkg::S_ADD_DECIDE:
            begin
                if (node_count_reg == NCW'(pmml_pkg::MAX_NODES))
                begin
                    res_status_next = pmml_pkg::ST_DROP;
                    state_next      = pmml_pkg::S_EMIT;
                end
                else
                begin
                    idx_next   = node_count_reg;
                    state_next = (node_count_reg == pos_reg) ? pmml_pkg::S_ADD_PUT
                                                             : pmml_pkg::S_ADD_SH_RD;
                end
            end

            pmml_pkg::S_ADD_SH_RD:
            begin
                node_raddr = pmml_pkg::NODE_AW'(idx_reg - 1'b1);
                state_next = pmml_pkg::S_ADD_SH_WR;
            end

            pmml_pkg::S_ADD_SH_WR:
            begin
                // move one entry up to open the slot at pos
                node_we    = 1'b1;
                idx_next   = NCW'(idx_reg - 1'b1);
                state_next = (NCW'(idx_reg - 1'b1) == pos_reg) ? pmml_pkg::S_ADD_PUT
                                                               : pmml_pkg::S_ADD_SH_RD;
            end

            pmml_pkg::S_ADD_PUT:
            begin
                node_we         = 1'b1;
                node_waddr      = pos_reg[pmml_pkg::NODE_AW-1:0];
                node_wdata      = na_reg;
                node_count_next = NCW'(node_count_reg + 1'b1);
                state_next      = pmml_pkg::S_EMIT;
            end

            pmml_pkg::S_LOAD_RD:
            begin
                state_next = pmml_pkg::S_LOAD_CMP;
            end

            pmml_pkg::S_LOAD_CMP:
            begin
                if (ent_rdata_reg.part == part_reg && ent_rdata_reg.node == na_reg)
                begin
                    state_next = pmml_pkg::S_EMIT;
                end
                else
                begin
                    eidx_next  = ECW'(eidx_reg + 1'b1);
                    state_next = scan_end ? pmml_pkg::S_LOAD_DECIDE : pmml_pkg::S_LOAD_RD;
                end
            end

            pmml_pkg::S_LOAD_DECIDE:
            begin
                if (entry_count_reg == ECW'(pmml_pkg::MAX_ENTRIES))
                begin
                    res_status_next = pmml_pkg::ST_DROP;
                end
                else
                begin
                    ent_we           = 1'b1;
                    entry_count_next = ECW'(entry_count_reg + 1'b1);
                end
                state_next = pmml_pkg::S_EMIT;
            end

            pmml_pkg::S_NODE_RD:
            begin
                state_next = pmml_pkg::S_NODE_GOT;
            end

            pmml_pkg::S_NODE_GOT:
            begin
                key_next   = node_rdata_reg;
                eidx_next  = '0;
                state_next = pmml_pkg::S_SCAN_START;
            end

            pmml_pkg::S_SCAN_START:
            begin
                state_next = (entry_count_reg == '0) ? pmml_pkg::S_SCAN_DONE
                                                     : pmml_pkg::S_ENT_RD;
            end

            pmml_pkg::S_ENT_RD:
            begin
                state_next = pmml_pkg::S_ENT_GOT;
            end

            pmml_pkg::S_ENT_GOT:
            begin
                hold_part_next = ent_rdata_reg.part;
                hold_w_next    = ent_rdata_reg.weight;
                if (ent_rdata_reg.node == key_reg)
                begin
                    state_next = pmml_pkg::S_TAB_GOT;
                end
                else
                begin
                    eidx_next  = ECW'(eidx_reg + 1'b1);
                    state_next = scan_end ? pmml_pkg::S_SCAN_DONE : pmml_pkg::S_ENT_RD;
                end
            end

            pmml_pkg::S_TAB_GOT:
            begin
                if (!sum_phase_reg)
                begin
                    // build pass: per-particle sum of weights over the key nodes
                    tab_we                    = 1'b1;
                    valid_next[hold_part_reg] = 1'b1;
                    eidx_next                 = ECW'(eidx_reg + 1'b1);
                    state_next = scan_end ? pmml_pkg::S_SCAN_DONE : pmml_pkg::S_ENT_RD;
                end
                else if (valid_reg[hold_part_reg])
                begin
                    mac_ctrl.ld = 1'b1;
                    state_next  = pmml_pkg::S_MUL2;
                end
                else
                begin
                    eidx_next  = ECW'(eidx_reg + 1'b1);
                    state_next = scan_end ? pmml_pkg::S_SCAN_DONE : pmml_pkg::S_ENT_RD;
                end
            end

            pmml_pkg::S_MUL2:
            begin
                mac_ctrl.mul = 1'b1;
                state_next   = pmml_pkg::S_ACC;
            end

            pmml_pkg::S_ACC:
            begin
                mac_ctrl.acc = 1'b1;
                eidx_next    = ECW'(eidx_reg + 1'b1);
                state_next   = scan_end ? pmml_pkg::S_SCAN_DONE : pmml_pkg::S_ENT_RD;
            end

            pmml_pkg::S_SCAN_DONE:
            begin
                eidx_next = '0;
                if (act_reg == pmml_pkg::ACT_QUERY)
                begin
                    if (!sum_phase_reg)
                    begin
                        sum_phase_next = 1'b1;
                        key_next       = nb_reg;
                        mac_ctrl.clr   = 1'b1;
                        state_next     = pmml_pkg::S_SCAN_START;
                    end
                    else
                    begin
                        state_next = pmml_pkg::S_EMIT;
                    end
                end
                else if (!sum_phase_reg)
                begin
                    state_next = pmml_pkg::S_NODE_RD;
                    if (node_end)
                    begin
                        sum_phase_next = 1'b1;
                        idx_next       = '0;
                        mac_ctrl.clr   = 1'b1;
                    end
                    else
                    begin
                        idx_next = NCW'(idx_reg + 1'b1);
                    end
                end
                else
                begin
                    res_node_next = key_reg;
                    res_last_next = node_end;
                    state_next    = pmml_pkg::S_EMIT;
                end
            end

            pmml_pkg::S_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next   = 1'b1;
                    out_value_next  = mac_acc;
                    out_node_next   = res_node_reg;
                    out_status_next = res_status_reg;
                    out_last_next   = res_last_reg;
                    if (act_reg == pmml_pkg::ACT_LUMP && !res_last_reg)
                    begin
                        idx_next     = NCW'(idx_reg + 1'b1);
                        mac_ctrl.clr = 1'b1;
                        state_next   = pmml_pkg::S_NODE_RD;
                    end
                    else
                    begin
                        state_next = pmml_pkg::S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = pmml_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= pmml_pkg::S_IDLE;
            act_reg         <= pmml_pkg::ACT_ADD;
            mass_reg        <= pmml_pkg::MASS_RESET;
            node_count_reg  <= '0;
            entry_count_reg <= '0;
            idx_reg         <= '0;
            pos_reg         <= '0;
            eidx_reg        <= '0;
            sum_phase_reg   <= 1'b0;
            valid_reg       <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            act_reg         <= act_next;
            mass_reg        <= mass_next;
            node_count_reg  <= node_count_next;
            entry_count_reg <= entry_count_next;
            idx_reg         <= idx_next;
            pos_reg         <= pos_next;
            eidx_reg        <= eidx_next;
            sum_phase_reg   <= sum_phase_next;
            valid_reg       <= valid_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg       <= part_next;
        na_reg         <= na_next;
        nb_reg         <= nb_next;
        w_reg          <= w_next;
        key_reg        <= key_next;
        hold_part_reg  <= hold_part_next;
        hold_w_reg     <= hold_w_next;
        res_node_reg   <= res_node_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
        out_value_reg  <= out_value_next;
        out_node_reg   <= out_node_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_node_reg, (pmml_pkg::VALUE_W - pmml_pkg::ACC_W)'(0),
                       out_value_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== hw/rtl/pmml_checker.sv =====
`timescale 1ns / 1ps

module pmml_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // one item at a time: a known action keeps the input busy after its transfer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser <= pmml_pkg::ACT_CLEAR)) |=> !s_tready)
        else $error("input accepted back to back");

    // sums are bounded well below the saturation point
    a_no_saturation: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser != pmml_pkg::ST_SAT))
        else $error("saturated status reported");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == pmml_pkg::ST_EMPTY) |-> (m_tlast && m_tdata == 80'd0))
        else $error("empty node set result malformed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind particle_mass_matrix_lumper pmml_checker u_pmml_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== dv/particle_mass_matrix_lumper_tb.sv =====
`timescale 1ns / 1ps

module particle_mass_matrix_lumper_tb;

    localparam logic [63:0] VALUE_TOP = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int RANDOM_ITEMS = 310;
    localparam logic [2:0] MASS_ADDR = 3'd0;

    typedef struct {
        logic [62:0] value;
        logic [15:0] node;
        logic [1:0]  status;
        logic        last;
    } mass_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;   // particle[7:0], node_a[23:8], node_b[39:24], weight[55:40]
    logic [2:0]  s_tuser = '0;   // action[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;        // value[62:0], node[78:63], zero pad[79]
    logic [1:0]  m_tuser;        // status[1:0]
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    particle_mass_matrix_lumper dut
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 clk = ~clk;

    // shadow state of the block
    logic [15:0] mass_reg = pmml_pkg::MASS_RESET;
    logic [15:0] node_set[$];
    logic [7:0]  ent_part[$];
    logic [15:0] ent_node[$];
    logic [15:0] ent_wt[$];

    mass_result_t pending_results[$];
    int errors = 0;
    int cycles = 0;
    int rx_hold = 0;
    int rx_wait = 0;
    bit no_idle = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] acc, input logic [63:0] t,
                                            inout bit sat);
        if (t > VALUE_TOP - acc)
        begin
            sat = 1'b1;
            return VALUE_TOP;
        end
        return acc + t;
    endfunction

    function automatic logic [63:0] mass_element(input logic [15:0] a, input logic [15:0] b,
                                                 inout bit sat);
        logic [15:0] wa[256];
        logic [15:0] wb[256];
        bit          ha[256];
        bit          hb[256];
        logic [63:0] acc;
        logic [63:0] t;
        acc = '0;
        for (int p = 0; p < 256; p++)
        begin
            ha[p] = 1'b0;
            hb[p] = 1'b0;
        end
        for (int e = 0; e < ent_part.size(); e++)
        begin
            if (ent_node[e] == a)
            begin
                wa[ent_part[e]] = ent_wt[e];
                ha[ent_part[e]] = 1'b1;
            end
            if (ent_node[e] == b)
            begin
                wb[ent_part[e]] = ent_wt[e];
                hb[ent_part[e]] = 1'b1;
            end
        end
        for (int p = 0; p < 256; p++)
            if (ha[p] && hb[p])
            begin
                t = 64'(mass_reg) * 64'(wa[p]) * 64'(wb[p]);
                acc = sat_add(acc, t, sat);
            end
        return acc;
    endfunction

    function automatic void push_result(input logic [63:0] v, input logic [15:0] n,
                                        input logic [1:0] st, input logic lst);
        mass_result_t r;
        r.value = v[62:0];
        r.node = n;
        r.status = st;
        r.last = lst;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_lumper(input logic [2:0] act, input logic [7:0] part,
                                           input logic [15:0] na, input logic [15:0] nb,
                                           input logic [15:0] w);
        bit          sat;
        bit          dup;
        int          pos;
        logic [63:0] v;
        logic [1:0]  st;
        case (act)
            pmml_pkg::ACT_ADD:
            begin
                dup = 1'b0;
                pos = 0;
                foreach (node_set[i])
                begin
                    if (node_set[i] == na)
                        dup = 1'b1;
                    if (node_set[i] < na)
                        pos = i + 1;
                end
                st = pmml_pkg::ST_OK;
                if (!dup)
                begin
                    if (node_set.size() >= pmml_pkg::MAX_NODES)
                        st = pmml_pkg::ST_DROP;
                    else
                        node_set.insert(pos, na);
                end
                push_result('0, na, st, 1'b1);
            end
            pmml_pkg::ACT_LOAD:
            begin
                dup = 1'b0;
                foreach (ent_part[e])
                    if (ent_part[e] == part && ent_node[e] == na)
                        dup = 1'b1;
                st = pmml_pkg::ST_OK;
                if (!dup)
                begin
                    if (ent_part.size() >= pmml_pkg::MAX_ENTRIES)
                        st = pmml_pkg::ST_DROP;
                    else
                    begin
                        ent_part.push_back(part);
                        ent_node.push_back(na);
                        ent_wt.push_back(w);
                    end
                end
                push_result('0, na, st, 1'b1);
            end
            pmml_pkg::ACT_LUMP:
            begin
                if (node_set.size() == 0)
                    push_result('0, '0, pmml_pkg::ST_EMPTY, 1'b1);
                foreach (node_set[i])
                begin
                    sat = 1'b0;
                    v = '0;
                    foreach (node_set[j])
                        v = sat_add(v, mass_element(node_set[i], node_set[j], sat), sat);
                    push_result(v, node_set[i], sat ? pmml_pkg::ST_SAT : pmml_pkg::ST_OK,
                                i + 1 == node_set.size());
                end
            end
            pmml_pkg::ACT_QUERY:
            begin
                sat = 1'b0;
                v = mass_element(na, nb, sat);
                push_result(v, na, sat ? pmml_pkg::ST_SAT : pmml_pkg::ST_OK, 1'b1);
            end
            pmml_pkg::ACT_CLEAR:
            begin
                node_set.delete();
                ent_part.delete();
                ent_node.delete();
                ent_wt.delete();
                push_result('0, '0, pmml_pkg::ST_OK, 1'b1);
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    task automatic send_item(input logic [2:0] act, input logic [7:0] part,
                             input logic [15:0] na, input logic [15:0] nb,
                             input logic [15:0] w);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {w, nb, na, part};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_lumper(act, part, na, nb, w);
    endtask

    // hold the sender until every expected result has come, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_mass(input logic [15:0] m);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= MASS_ADDR;
        pwdata <= {16'd0, m};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        mass_reg = m;
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end
        else if (rx_wait > 0)
        begin
            m_tready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end
        else if (pick_gap() > 0)
        begin
            m_tready <= 1'b0;
            rx_wait <= pick_gap();
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                mass_result_t r;
                r = pending_results.pop_front();
                if (m_tdata[62:0] != r.value)
                    report_mismatch($sformatf("value %0h, want %0h", m_tdata[62:0], r.value));
                if (m_tdata[78:63] != r.node)
                    report_mismatch($sformatf("node %0h, want %0h", m_tdata[78:63], r.node));
                if (m_tuser != r.status)
                    report_mismatch($sformatf("status %0d, want %0d", m_tuser, r.status));
                if (m_tlast != r.last)
                    report_mismatch($sformatf("last %0b, want %0b", m_tlast, r.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[particle_mass_matrix_lumper] ERROR");
            $finish;
        end
    end

    task automatic test_empty_and_ignored();
        send_item(pmml_pkg::ACT_LUMP, 8'd0, 16'd0, 16'd0, 16'd0);
        send_item(pmml_pkg::ACT_QUERY, 8'd0, 16'd5, 16'd5, 16'd0);
        send_item(3'd5, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(3'd6, 8'd0, 16'd0, 16'd0, 16'd0);
        send_item(3'd7, 8'h55, 16'hAAAA, 16'h5555, 16'h8000);
        drain();
    endtask

    task automatic test_extremes();
        send_item(pmml_pkg::ACT_ADD, 8'd0, 16'hFFFF, 16'd0, 16'd0);
        send_item(pmml_pkg::ACT_ADD, 8'd0, 16'd0, 16'd0, 16'd0);
        send_item(pmml_pkg::ACT_ADD, 8'd0, 16'd0, 16'd0, 16'd0);
        send_item(pmml_pkg::ACT_LOAD, 8'd0, 16'd0, 16'd0, 16'h8000);
        send_item(pmml_pkg::ACT_LOAD, 8'hFF, 16'hFFFF, 16'd0, 16'h8000);
        send_item(pmml_pkg::ACT_LOAD, 8'd0, 16'hFFFF, 16'd0, 16'h0000);
        send_item(pmml_pkg::ACT_LOAD, 8'hFF, 16'd0, 16'd0, 16'h7FFF);
        // repeated pair: the first weight stays
        send_item(pmml_pkg::ACT_LOAD, 8'd0, 16'd0, 16'd0, 16'd1);
        send_item(pmml_pkg::ACT_QUERY, 8'd0, 16'd0, 16'hFFFF, 16'd0);
        send_item(pmml_pkg::ACT_QUERY, 8'd0, 16'hFFFF, 16'hFFFF, 16'd0);
        send_item(pmml_pkg::ACT_LUMP, 8'd0, 16'd0, 16'd0, 16'd0);
        drain();
        write_mass(16'hFFFF);
        send_item(pmml_pkg::ACT_QUERY, 8'd0, 16'd0, 16'd0, 16'd0);
        send_item(pmml_pkg::ACT_LUMP, 8'd0, 16'd0, 16'd0, 16'd0);
        drain();
        write_mass(16'd0);
        send_item(pmml_pkg::ACT_QUERY, 8'd0, 16'd0, 16'd0, 16'd0);
        send_item(pmml_pkg::ACT_LUMP, 8'd0, 16'd0, 16'd0, 16'd0);
        drain();
        write_mass(pmml_pkg::MASS_RESET);
        send_item(pmml_pkg::ACT_CLEAR, 8'd0, 16'd0, 16'd0, 16'd0);
        send_item(pmml_pkg::ACT_QUERY, 8'd0, 16'd0, 16'd0, 16'd0);
        drain();
    endtask

    task automatic test_node_set_full();
        logic [15:0] n;
        for (int i = 0; i < 66; i++)
        begin
            n = 16'($urandom);
            send_item(pmml_pkg::ACT_ADD, 8'd0, n, 16'd0, 16'd0);
            if (i == 3)
            begin
                send_item(pmml_pkg::ACT_LOAD, 8'd7, n, 16'd0, 16'h8000);
                send_item(pmml_pkg::ACT_LOAD, 8'd9, n, 16'd0, 16'($urandom_range(0, 32768)));
            end
        end
        send_item(pmml_pkg::ACT_ADD, 8'd0, node_set[10], 16'd0, 16'd0);
        send_item(pmml_pkg::ACT_LUMP, 8'd0, 16'd0, 16'd0, 16'd0);
        send_item(pmml_pkg::ACT_CLEAR, 8'd0, 16'd0, 16'd0, 16'd0);
        drain();
    endtask

    task automatic test_entry_store_full();
        no_idle = 1'b1;
        for (int i = 0; i < pmml_pkg::MAX_ENTRIES + 1; i++)
            send_item(pmml_pkg::ACT_LOAD, 8'(i), 16'(i / 256), 16'd0,
                      16'($urandom_range(0, 32768)));
        send_item(pmml_pkg::ACT_LOAD, 8'd3, 16'd0, 16'd0, 16'd9);
        send_item(pmml_pkg::ACT_ADD, 8'd0, 16'd1, 16'd0, 16'd0);
        send_item(pmml_pkg::ACT_QUERY, 8'd0, 16'd1, 16'd2, 16'd0);
        send_item(pmml_pkg::ACT_LUMP, 8'd0, 16'd0, 16'd0, 16'd0);
        send_item(pmml_pkg::ACT_CLEAR, 8'd0, 16'd0, 16'd0, 16'd0);
        no_idle = 1'b0;
        drain();
    endtask

    task automatic test_backpressure();
        rx_hold = 2000;
        for (int i = 0; i < 30; i++)
            send_item(i % 3 == 0 ? pmml_pkg::ACT_ADD : pmml_pkg::ACT_LOAD,
                      8'($urandom_range(0, 7)),
                      16'($urandom_range(0, 5)), 16'd0, 16'($urandom_range(0, 32768)));
        send_item(pmml_pkg::ACT_LUMP, 8'd0, 16'd0, 16'd0, 16'd0);
        drain();
        send_item(pmml_pkg::ACT_CLEAR, 8'd0, 16'd0, 16'd0, 16'd0);
        drain();
    endtask

    task automatic test_random_phases();
        logic [15:0] pool[8];
        logic [7:0]  pbase;
        int          done;
        int          phase;
        done = 0;
        phase = 0;
        while (done < RANDOM_ITEMS)
        begin
            if (phase % 3 == 2)
            begin
                drain();
                case ($urandom_range(0, 3))
                    0: write_mass(16'hFFFF);
                    1: write_mass(16'd0);
                    default: write_mass(16'($urandom));
                endcase
            end
            no_idle = (phase % 5 == 4);
            foreach (pool[i])
                pool[i] = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 3)) : 16'($urandom);
            pbase = 8'($urandom_range(0, 250));
            send_item(pmml_pkg::ACT_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
            done++;
            repeat ($urandom_range(1, 6))
            begin
                send_item(pmml_pkg::ACT_ADD, 8'($urandom), pool[$urandom_range(0, 7)],
                          16'($urandom), 16'($urandom));
                done++;
            end
            repeat ($urandom_range(3, 14))
            begin
                send_item(pmml_pkg::ACT_LOAD, pbase + 8'($urandom_range(0, 5)),
                          pool[$urandom_range(0, 7)], 16'($urandom),
                          $urandom_range(0, 4) == 0 ? 16'h8000 : 16'($urandom_range(0, 32768)));
                done++;
                if ($urandom_range(0, 7) == 0)
                    send_item(3'($urandom_range(5, 7)), 8'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom));
            end
            repeat ($urandom_range(1, 4))
            begin
                send_item(pmml_pkg::ACT_QUERY, 8'($urandom), pool[$urandom_range(0, 7)],
                          $urandom_range(0, 5) == 0 ? 16'($urandom) : pool[$urandom_range(0, 7)],
                          16'($urandom));
                done++;
            end
            send_item(pmml_pkg::ACT_LUMP, 8'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
            done++;
            phase++;
        end
        no_idle = 1'b0;
        drain();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_empty_and_ignored();
        test_extremes();
        test_node_set_full();
        test_backpressure();
        test_random_phases();
        test_entry_store_full();
        if (errors == 0)
            $display("[particle_mass_matrix_lumper] OK");
        else
            $display("[particle_mass_matrix_lumper] ERROR");
        $finish;
    end

endmodule
